// ===== design/cpd_pkg.sv =====
package cpd_pkg;

    // Largest end marker the window can hold, and largest decoded length field.
    localparam int CPD_MARKER_MAX    = 4;
    localparam int CPD_LEN_FIELD_MAX = 4;

    localparam int CPD_CFG_IDX_W = 3;

    typedef enum logic [CPD_CFG_IDX_W-1:0] {
        CFG_PREAMBLE_LEN = 3'd0,
        CFG_LENGTH_BYTES = 3'd1,
        CFG_BIG_ENDIAN   = 3'd2,
        CFG_DATETIME_LEN = 3'd3,
        CFG_MARKER_LEN   = 3'd4,
        CFG_MARKER_BYTES = 3'd5
    } cpd_cfg_idx_t;

    typedef enum logic [2:0] {
        PH_PRE  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TS   = 3'd2,
        PH_PAY  = 3'd3,
        PH_TAIL = 3'd4,
        PH_SRCH = 3'd5
    } cpd_phase_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_SHORT_LEN  = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAMING = 2'd2;

    typedef struct packed {
        logic [3:0]  preamble_len;
        logic [2:0]  length_bytes;
        logic        big_endian;
        logic [3:0]  datetime_len;
        logic [2:0]  marker_len;
        logic [31:0] marker_bytes;
    } cpd_cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last;
        logic       empty_frame;
        logic [1:0] status;
    } cpd_result_t;

    // Marker byte at position idx; positions past the packed word compare as zero.
    function automatic logic [7:0] cpd_marker_byte(input logic [31:0] bytes,
                                                   input int unsigned idx);
        logic [31:0] shifted;
        shifted = bytes >> {idx[1:0], 3'b000};
        return (idx < 4) ? shifted[7:0] : 8'd0;
    endfunction

endpackage

// ===== design/cpd_cfg_regs.sv =====
module cpd_cfg_regs
    import cpd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [CPD_CFG_IDX_W-1:0] wr_index,
    input  logic [31:0]              wr_data,
    output cpd_cfg_t                 cfg
);

    cpd_cfg_t cfg_reg;
    cpd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_PREAMBLE_LEN: cfg_next.preamble_len = wr_data[3:0];
                CFG_LENGTH_BYTES: cfg_next.length_bytes = wr_data[2:0];
                CFG_BIG_ENDIAN:   cfg_next.big_endian   = wr_data[0];
                CFG_DATETIME_LEN: cfg_next.datetime_len = wr_data[3:0];
                CFG_MARKER_LEN:   cfg_next.marker_len   = wr_data[2:0];
                CFG_MARKER_BYTES: cfg_next.marker_bytes = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preamble_len <= 4'd0;
            cfg_reg.length_bytes <= 3'd2;
            cfg_reg.big_endian   <= 1'b1;
            cfg_reg.datetime_len <= 4'd0;
            cfg_reg.marker_len   <= 3'd0;
            cfg_reg.marker_bytes <= 32'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/cpd_step.sv =====
module cpd_step
    import cpd_pkg::*;
#(
    parameter int MARKER_MAX = CPD_MARKER_MAX
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cpd_cfg_t    cfg,
    input  logic        step_en,
    input  logic [7:0]  in_byte,
    output logic        res_valid,
    output cpd_result_t res
);

    localparam int FILL_W = $clog2(MARKER_MAX + 1);

    cpd_phase_t        phase_reg, phase_next;
    logic [3:0]        bc_reg, bc_next;
    logic [31:0]       acc_reg, acc_next;
    logic [FILL_W-1:0] wf_reg, wf_next;
    logic [7:0]        win_reg  [MARKER_MAX];
    logic [7:0]        win_next [MARKER_MAX];
    logic [7:0]        win_up   [MARKER_MAX];

    logic [FILL_W-1:0] mlen;
    logic              no_frame;
    logic              pre_done;
    cpd_phase_t        hdr_phase;
    cpd_phase_t        phase_eff;
    logic [3:0]        bc_eff;
    logic [31:0]       acc_eff;
    logic [FILL_W-1:0] wf_eff;
    logic [4:0]        bc_inc;

    logic [31:0]       acc_shift;
    logic              len_done;
    logic [31:0]       len_value;
    logic              short_len;
    logic [31:0]       len_rem;
    logic              ts_done;
    logic [31:0]       acc_dec;
    logic              pay_last;
    logic              tail_done;
    logic [FILL_W-1:0] wf_clamp;
    logic              has_out;
    logic              mismatch;
    logic              match;

    // Clamp the marker length to what the window holds.
    always_comb begin
        if (int'(cfg.marker_len) > MARKER_MAX) begin
            mlen = FILL_W'(MARKER_MAX);
        end else begin
            mlen = FILL_W'(cfg.marker_len);
        end
    end

    assign no_frame  = (cfg.length_bytes == 3'd0) && (mlen == '0);
    assign pre_done  = (phase_reg == PH_PRE) && (bc_reg >= cfg.preamble_len);
    assign hdr_phase = (cfg.length_bytes != 3'd0) ? PH_LEN :
                       (cfg.datetime_len == 4'd0) ? PH_SRCH : PH_TS;

    // A finished preamble hands this byte straight to the header.
    assign phase_eff = pre_done ? hdr_phase : phase_reg;
    assign bc_eff    = pre_done ? 4'd0 : bc_reg;
    assign acc_eff   = pre_done ? 32'd0 : acc_reg;
    assign wf_eff    = pre_done ? '0 : wf_reg;
    assign bc_inc    = {1'b0, bc_eff} + 5'd1;

    // Length field assembly and decode.
    always_comb begin
        if (cfg.big_endian) begin
            acc_shift = {acc_eff[23:0], in_byte};
        end else if (bc_eff < 4'd4) begin
            acc_shift = acc_eff | (32'(in_byte) << {bc_eff[1:0], 3'b000});
        end else begin
            acc_shift = acc_eff;
        end
    end

    assign len_done  = bc_inc >= {2'b00, cfg.length_bytes};
    assign len_value = ((cfg.length_bytes == 3'd1 || cfg.length_bytes == 3'd2 ||
                         cfg.length_bytes == 3'd4) &&
                        int'(cfg.length_bytes) <= CPD_LEN_FIELD_MAX) ? acc_shift : 32'd0;
    assign short_len = len_value < 32'(cfg.datetime_len);
    assign len_rem   = len_value - 32'(cfg.datetime_len);

    assign ts_done   = bc_inc >= {1'b0, cfg.datetime_len};
    assign acc_dec   = (acc_eff != 32'd0) ? acc_eff - 32'd1 : acc_eff;
    assign pay_last  = acc_dec == 32'd0;
    assign tail_done = bc_inc >= 5'(mlen);

    // Marker window: fill from the front, then slide by one.
    assign wf_clamp = (wf_eff > mlen) ? mlen : wf_eff;
    assign has_out  = wf_clamp == mlen;

    for (genvar g = 0; g < MARKER_MAX; g++) begin : g_up
        if (g < MARKER_MAX - 1) begin : g_mid
            assign win_up[g] = win_reg[g+1];
        end else begin : g_end
            assign win_up[g] = win_reg[g];
        end
    end

    always_comb begin
        for (int k = 0; k < MARKER_MAX; k++) begin
            if (wf_clamp < mlen) begin
                win_next[k] = (FILL_W'(k) == wf_clamp) ? in_byte : win_reg[k];
            end else if (k + 1 < int'(mlen)) begin
                win_next[k] = win_up[k];
            end else if (k + 1 == int'(mlen)) begin
                win_next[k] = in_byte;
            end else begin
                win_next[k] = win_reg[k];
            end
        end
    end

    always_comb begin
        mismatch = 1'b0;
        for (int k = 0; k < MARKER_MAX; k++) begin
            if (k < int'(mlen) &&
                win_next[k] != cpd_marker_byte(cfg.marker_bytes, k)) begin
                mismatch = 1'b1;
            end
        end
    end

    // A match needs a full window, either already full or filled by this byte.
    assign match = (has_out || (wf_clamp + FILL_W'(1)) == mlen) && !mismatch;

    // Next state.
    always_comb begin
        phase_next = phase_eff;
        bc_next    = bc_eff;
        acc_next   = acc_eff;
        wf_next    = wf_eff;
        if (no_frame) begin
            phase_next = PH_PRE;
            bc_next    = 4'd0;
            acc_next   = 32'd0;
            wf_next    = '0;
        end else begin
            unique case (phase_eff)
                PH_PRE: begin
                    bc_next = bc_inc[3:0];
                    if (bc_inc >= {1'b0, cfg.preamble_len}) begin
                        phase_next = hdr_phase;
                        bc_next    = 4'd0;
                        acc_next   = 32'd0;
                        wf_next    = '0;
                    end
                end
                PH_LEN: begin
                    if (!len_done) begin
                        acc_next = acc_shift;
                        bc_next  = bc_inc[3:0];
                    end else if (short_len) begin
                        phase_next = PH_PRE;
                        bc_next    = 4'd0;
                        acc_next   = 32'd0;
                        wf_next    = '0;
                    end else begin
                        acc_next   = len_rem;
                        bc_next    = 4'd0;
                        phase_next = PH_TS;
                        if (cfg.datetime_len == 4'd0) begin
                            if (len_rem == 32'd0) begin
                                if (mlen == '0) begin
                                    phase_next = PH_PRE;
                                    acc_next   = 32'd0;
                                    wf_next    = '0;
                                end else begin
                                    phase_next = PH_TAIL;
                                end
                            end else begin
                                phase_next = PH_PAY;
                            end
                        end
                    end
                end
                PH_TS: begin
                    bc_next = bc_inc[3:0];
                    if (ts_done) begin
                        bc_next = 4'd0;
                        if (cfg.length_bytes != 3'd0) begin
                            if (acc_eff == 32'd0) begin
                                if (mlen == '0) begin
                                    phase_next = PH_PRE;
                                    wf_next    = '0;
                                end else begin
                                    phase_next = PH_TAIL;
                                end
                            end else begin
                                phase_next = PH_PAY;
                            end
                        end else begin
                            wf_next    = '0;
                            phase_next = PH_SRCH;
                        end
                    end
                end
                PH_PAY: begin
                    acc_next = acc_dec;
                    if (pay_last) begin
                        bc_next = 4'd0;
                        if (mlen == '0) begin
                            phase_next = PH_PRE;
                            wf_next    = '0;
                        end else begin
                            phase_next = PH_TAIL;
                        end
                    end
                end
                PH_TAIL: begin
                    bc_next = bc_inc[3:0];
                    if (tail_done) begin
                        phase_next = PH_PRE;
                        bc_next    = 4'd0;
                        acc_next   = 32'd0;
                        wf_next    = '0;
                    end
                end
                PH_SRCH: begin
                    if (mlen == '0 || match) begin
                        phase_next = PH_PRE;
                        bc_next    = 4'd0;
                        acc_next   = 32'd0;
                        wf_next    = '0;
                    end else begin
                        wf_next = has_out ? wf_clamp : wf_clamp + FILL_W'(1);
                    end
                end
                default: begin
                    phase_next = PH_PRE;
                    bc_next    = 4'd0;
                    acc_next   = 32'd0;
                    wf_next    = '0;
                end
            endcase
        end
    end

    // Result for this byte.
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        if (no_frame) begin
            res_valid  = 1'b1;
            res.status = STATUS_NO_FRAMING;
        end else begin
            unique case (phase_eff)
                PH_LEN: begin
                    if (len_done && short_len) begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        res.status = STATUS_SHORT_LEN;
                    end else if (len_done && cfg.datetime_len == 4'd0 &&
                                 len_rem == 32'd0) begin
                        res_valid       = 1'b1;
                        res.last        = 1'b1;
                        res.empty_frame = 1'b1;
                    end
                end
                PH_TS: begin
                    if (ts_done && cfg.length_bytes != 3'd0 && acc_eff == 32'd0) begin
                        res_valid       = 1'b1;
                        res.last        = 1'b1;
                        res.empty_frame = 1'b1;
                    end
                end
                PH_PAY: begin
                    res_valid        = 1'b1;
                    res.payload_byte = in_byte;
                    res.last         = pay_last;
                end
                PH_SRCH: begin
                    if (mlen != '0 && has_out) begin
                        res_valid        = 1'b1;
                        res.payload_byte = win_reg[0];
                        res.last         = match;
                    end else if (mlen != '0 && match) begin
                        res_valid       = 1'b1;
                        res.last        = 1'b1;
                        res.empty_frame = 1'b1;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PRE;
            bc_reg    <= 4'd0;
            acc_reg   <= 32'd0;
            wf_reg    <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            acc_reg   <= acc_next;
            wf_reg    <= wf_next;
        end
    end

    // Window bytes are only read once filled; they need no reset.
    always_ff @(posedge aclk) begin
        if (step_en && !no_frame && phase_eff == PH_SRCH && mlen != '0) begin
            win_reg <= win_next;
        end
    end

endmodule

// ===== design/cpd_out_stage.sv =====
module cpd_out_stage
    import cpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  cpd_result_t res,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic [2:0]  m_tuser
);

    logic        valid_reg, valid_next;
    cpd_result_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tlast  = res_reg.last;
    assign m_tuser  = {res_reg.status, res_reg.empty_frame};

endmodule

// ===== design/configurable_packet_deframer_core.sv =====
// Channel   Direction  Request fields
// s_*       in         tdata[7:0] in_byte
// m_*       out        tdata[7:0] payload_byte, tlast last,
//                      tuser[0] empty_frame, tuser[2:1] status
// cfg_*     in         cfg_index register number, cfg_data value
//
// One byte per cycle while m_* does not stall: every byte goes through an input
// register and the header/payload/marker logic, and a byte that yields a result
// lands in the result register, from which it is taken on m_*.
// aresetn is synchronous and active low; it restores the register defaults and
// drops into the preamble phase. No memory sweep follows reset.
// A stall on m_* holds the result register; the byte in the input register then
// waits and s_tready drops in that same cycle.
module configurable_packet_deframer_core
    import cpd_pkg::*;
#(
    parameter int MARKER_MAX = CPD_MARKER_MAX
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,    // [7:0] in_byte

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,    // [7:0] payload_byte
    output logic                     m_tlast,
    output logic [2:0]               m_tuser,    // [0] empty_frame, [2:1] status

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CPD_CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]              cfg_data
);

    cpd_cfg_t    cfg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        step_en;
    logic        res_valid;
    cpd_result_t res;
    logic        can_load;

    // Registers are to be written only while the stream is idle; not enforced, so always take a write.
    assign cfg_ready = 1'b1;

    cpd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held byte whenever the result register can take its result.
    assign step_en  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || step_en;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    cpd_step #(
        .MARKER_MAX (MARKER_MAX)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step_en   (step_en),
        .in_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    cpd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_en && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
